[rtl/aed_pkg.sv]
// ----------------------------------------------------------------------------
// aed_pkg
// Types and constants shared by the analog epoch decoder and its checker.
// ----------------------------------------------------------------------------
package aed_pkg;

  localparam int SAMPLE_W = 16;
  localparam int EPOCH_W  = 12;
  localparam int INDEX_W  = 6;
  localparam int SUM_W    = 19;
  localparam int DIV_W    = SUM_W + 1;
  localparam int QUOT_W   = 11;
  localparam int RECIP_W  = 20;
  localparam int PROD_W   = DIV_W + RECIP_W;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 16;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_DEFAULT = 2'd0;
  localparam mode_t MODE_NIDAQ   = 2'd1;
  localparam mode_t MODE_CMOS    = 2'd2;

  localparam logic [SAMPLE_W-1:0] HOLD_RESET = 16'd2048;
  localparam logic [SAMPLE_W-1:0] QUAL_LIMIT = 16'd4080;

  localparam logic [INDEX_W-1:0] INDEX_MAX   = 6'd63;
  localparam logic [INDEX_W-1:0] PULSE_FIRST = 6'd27;
  localparam logic [INDEX_W-1:0] PULSE_LAST  = 6'd46;
  localparam logic [INDEX_W-1:0] NIDAQ_FIRST = 6'd29;
  localparam logic [INDEX_W-1:0] NIDAQ_LAST  = 6'd34;
  localparam logic [INDEX_W-1:0] DEF_FIRST   = 6'd38;
  localparam logic [INDEX_W-1:0] DEF_LAST    = 6'd43;

  // Rounded division is mapped to floor((sum + BIAS) / DIV) - OFFSET, with
  // BIAS chosen so the dividend is never negative. The dividend is one bit
  // wider than the sum so the bias add cannot wrap.
  localparam logic [DIV_W-1:0] NIDAQ_BIAS = 20'd3552;
  localparam logic [DIV_W-1:0] DEF_BIAS   = 20'd159;
  localparam logic [EPOCH_W-1:0] NIDAQ_OFFSET = 12'd69;
  localparam logic [EPOCH_W-1:0] DEF_OFFSET   = 12'd33;

  // Exact reciprocals over the biased dividend range: ceil(2^k / div).
  localparam logic [RECIP_W-1:0] NIDAQ_RECIP = 20'd745655;  // 1/2880, k = 31
  localparam logic [RECIP_W-1:0] DEF_RECIP   = 20'd733431;  // 1/366,  k = 28
  localparam int NIDAQ_SHIFT = 31;
  localparam int DEF_SHIFT   = 28;

  localparam logic signed [EPOCH_W-1:0] EPOCH_MIN = -12'sd512;
  localparam logic signed [EPOCH_W-1:0] EPOCH_MAX = 12'sd1042;

endpackage

[rtl/analog_epoch_decoder_top.sv]
// Result path: the frame's last sample enters the frame capture stage, then passes
// the bias add, reciprocal multiply and output stages on its way to m_axis.
// Throughput: one sample per cycle unless backpressure stalls it; per-sample
// state updates on accept, and the four-stage result pipe collapses bubbles.
// Reset (rst, synchronous): mode 0, frame state cleared, held sample 2048,
// pipe emptied.
// ----------------------------------------------------------------------------
// analog_epoch_decoder_top
// Decodes a signed epoch number from one frame of analog context samples.
// ----------------------------------------------------------------------------
module analog_epoch_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  aed_pkg::mode_t                 cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [aed_pkg::TDATA_IN_W-1:0] s_axis_tdata,   // [15:0] sample
  input  logic                           s_axis_tlast,   // last_in_frame
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [aed_pkg::TDATA_OUT_W-1:0] m_axis_tdata   // [11:0] epoch, [15:12] 0
);
  import aed_pkg::*;

  mode_t mode;

  // Frame state
  logic [INDEX_W-1:0]  sample_index;
  logic [1:0]          qualify_count;
  logic [SAMPLE_W-1:0] held_sample;
  logic [SUM_W-1:0]    window_sum;

  logic [1:0]          qualify_count_next;
  logic [SAMPLE_W-1:0] held_sample_next;
  logic [SUM_W-1:0]    window_sum_next;

  logic [SAMPLE_W-1:0] sample;
  logic                in_pulse;
  logic                in_window;
  logic                qualifies;
  logic                accept;

  // Pipe stages
  logic                fin_valid;
  logic                fin_cmos;
  logic                fin_nidaq;
  logic [SAMPLE_W-1:0] fin_held;
  logic [SUM_W-1:0]    fin_sum;

  logic                div_valid;
  logic                div_cmos;
  logic                div_nidaq;
  logic [DIV_W-1:0]    div_num;
  logic [EPOCH_W-1:0]  div_cmos_epoch;

  logic                mul_valid;
  logic                mul_cmos;
  logic                mul_nidaq;
  logic [PROD_W-1:0]   mul_prod;
  logic [EPOCH_W-1:0]  mul_cmos_epoch;

  logic                out_ready;
  logic                mul_ready;
  logic                div_ready;
  logic                fin_ready;

  logic signed [SAMPLE_W:0]   held_diff;
  logic signed [SAMPLE_W:0]   held_adj;
  logic signed [SAMPLE_W-2:0] held_quot;
  logic [EPOCH_W-1:0]         cmos_epoch;
  logic [QUOT_W-1:0]          quot;
  logic [EPOCH_W-1:0]         avg_diff;
  logic [EPOCH_W-1:0]         avg_epoch;

  assign out_ready = !m_axis_tvalid || m_axis_tready;
  assign mul_ready = !mul_valid || out_ready;
  assign div_ready = !div_valid || mul_ready;
  assign fin_ready = !fin_valid || div_ready;

  assign s_axis_tready = fin_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata[SAMPLE_W-1:0];

  // Per-sample update
  always_comb begin
    in_pulse  = (sample_index >= PULSE_FIRST) && (sample_index <= PULSE_LAST);
    qualifies = in_pulse && (sample != HOLD_RESET) && (sample < QUAL_LIMIT) &&
                (qualify_count != 2'd3);
    qualify_count_next = qualify_count + {1'b0, qualifies};
    held_sample_next   = (in_pulse && qualify_count_next == 2'd2) ? sample : held_sample;

    case (mode)
      MODE_NIDAQ: in_window = (sample_index >= NIDAQ_FIRST) && (sample_index <= NIDAQ_LAST);
      MODE_CMOS:  in_window = 1'b0;
      default:    in_window = (sample_index >= DEF_FIRST) && (sample_index <= DEF_LAST);
    endcase
    window_sum_next = in_window ? window_sum + {{(SUM_W-SAMPLE_W){1'b0}}, sample} : window_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DEFAULT;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      qualify_count <= '0;
      held_sample   <= HOLD_RESET;
      window_sum    <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        sample_index  <= '0;
        qualify_count <= '0;
        held_sample   <= HOLD_RESET;
        window_sum    <= '0;
      end else begin
        if (sample_index != INDEX_MAX) begin
          sample_index <= sample_index + 1'b1;
        end
        qualify_count <= qualify_count_next;
        held_sample   <= held_sample_next;
        window_sum    <= window_sum_next;
      end
    end
  end

  // Stage 1: frame totals
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= accept && s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready) begin
      fin_cmos  <= (mode == MODE_CMOS);
      fin_nidaq <= (mode == MODE_NIDAQ);
      fin_held  <= held_sample_next;
      fin_sum   <= window_sum_next;
    end
  end

  // Stage 2: biased dividend; CMOS result (truncate toward zero, clamp high)
  always_comb begin
    held_diff = $signed({1'b0, fin_held}) - $signed({1'b0, HOLD_RESET});
    held_adj  = held_diff + (held_diff[SAMPLE_W] ? 17'sd3 : 17'sd0);
    held_quot = held_adj[SAMPLE_W:2];
    if (held_quot > $signed({{(SAMPLE_W-1-EPOCH_W){EPOCH_MAX[EPOCH_W-1]}}, EPOCH_MAX})) begin
      cmos_epoch = EPOCH_MAX;
    end else begin
      cmos_epoch = held_quot[EPOCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else if (div_ready) begin
      div_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      div_cmos       <= fin_cmos;
      div_nidaq      <= fin_nidaq;
      div_num        <= {1'b0, fin_sum} + (fin_nidaq ? NIDAQ_BIAS : DEF_BIAS);
      div_cmos_epoch <= cmos_epoch;
    end
  end

  // Stage 3: reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready) begin
      mul_cmos       <= div_cmos;
      mul_nidaq      <= div_nidaq;
      mul_prod       <= {{RECIP_W{1'b0}}, div_num} *
                        {{DIV_W{1'b0}}, (div_nidaq ? NIDAQ_RECIP : DEF_RECIP)};
      mul_cmos_epoch <= div_cmos_epoch;
    end
  end

  // Stage 4: quotient, offset, clamp high, result register
  // (a wrapped window sum after a mode change can push mode 0 past the top)
  always_comb begin
    if (mul_nidaq) begin
      quot     = QUOT_W'(mul_prod[PROD_W-1:NIDAQ_SHIFT]);
      avg_diff = {1'b0, quot} - NIDAQ_OFFSET;
    end else begin
      quot     = mul_prod[DEF_SHIFT +: QUOT_W];
      avg_diff = {1'b0, quot} - DEF_OFFSET;
    end
    if ($signed(avg_diff) > EPOCH_MAX) begin
      avg_epoch = EPOCH_MAX;
    end else begin
      avg_epoch = avg_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      m_axis_tdata <= {{(TDATA_OUT_W-EPOCH_W){1'b0}},
                       (mul_cmos ? mul_cmos_epoch : avg_epoch)};
    end
  end

endmodule

[rtl/aed_checker.sv]
// ----------------------------------------------------------------------------
// aed_checker
// Port-level checks on the epoch decoder's result stream.
// ----------------------------------------------------------------------------
module aed_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [aed_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
  import aed_pkg::*;

  logic signed [EPOCH_W-1:0] epoch;
  assign epoch = $signed(m_axis_tdata[EPOCH_W-1:0]);

  // No result may be left over from before reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> m_axis_tdata[TDATA_OUT_W-1:EPOCH_W] == '0)
    else $error("tdata padding not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (epoch >= EPOCH_MIN) && (epoch <= EPOCH_MAX))
    else $error("epoch out of range");

endmodule

bind analog_epoch_decoder_top aed_checker u_aed_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_analog_epoch_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_analog_epoch_decoder_top
// Self-checking bench for the analog epoch decoder. Frames of samples go in on
// s_axis and a predictor tracks the pulse pick, window sums and rounding for
// every mode. Each epoch beat on m_axis is checked against the oldest frame
// still waiting. Both stream sides idle at random, and the mode changes
// between and inside frames.
// ----------------------------------------------------------------------------
module tb_analog_epoch_decoder_top;
  import aed_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;

  // rounding terms, scaled by six so the window sum is used directly
  localparam longint NIDAQ_CENTER = 196608;
  localparam longint NIDAQ_DEN    = 2880;
  localparam longint DEF_CENTER   = 12102;
  localparam longint DEF_DEN      = 366;

  localparam int RAND_ITEMS    = 560;
  localparam int RAND_FRAMES   = 50;
  localparam int CALM_AFTER    = 460;
  localparam int HOLD_AT_FRAME = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [SAMPLE_W-1:0] EDGE_VALUES [9] = '{
    16'd0, 16'd2047, 16'd2048, 16'd2049, 16'd4079, 16'd4080, 16'd4081,
    16'd32768, 16'hFFFF
  };

  typedef enum {STY_CONST, STY_LEVEL, STY_NOISE, STY_PULSE} frame_style_t;

  class epoch_scoreboard;
    mode_t                  mode;
    logic [INDEX_W-1:0]     index;
    logic [1:0]             qual_count;
    logic [SAMPLE_W-1:0]    held;
    logic [SUM_W-1:0]       win_sum;
    logic [TDATA_OUT_W-1:0] epoch_q[$];
    int                     mismatches;

    function new();
      mode       = MODE_DEFAULT;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      index      = '0;
      qual_count = '0;
      held       = HOLD_RESET;
      win_sum    = '0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function int pending();
      return epoch_q.size();
    endfunction

    function longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
    endfunction

    function void log_mismatch(string what, logic [TDATA_OUT_W-1:0] exp_v,
                               logic [TDATA_OUT_W-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch: %s  expected 0x%03h  got 0x%03h",
                 $realtime, what, exp_v, act_v);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic last);
      longint e;
      longint t;
      logic   in_win;
      if (index >= PULSE_FIRST && index <= PULSE_LAST) begin
        if (s != HOLD_RESET && s < QUAL_LIMIT && qual_count != 2'd3) qual_count++;
        // keeps tracking while exactly two qualifiers seen, qualifying or not
        if (qual_count == 2'd2) held = s;
      end
      case (mode)
        MODE_NIDAQ: in_win = (index >= NIDAQ_FIRST && index <= NIDAQ_LAST);
        MODE_CMOS:  in_win = 1'b0;
        default:    in_win = (index >= DEF_FIRST && index <= DEF_LAST);
      endcase
      if (in_win) win_sum = win_sum + s;  // wraps at SUM_W
      if (!last) begin
        if (index != INDEX_MAX) index++;
        return;
      end
      case (mode)
        MODE_CMOS: begin
          t = longint'(held) - longint'(HOLD_RESET);
          e = (t >= 0) ? t / 4 : -((-t) / 4);
        end
        MODE_NIDAQ: e = floor_div(2 * (longint'(win_sum) - NIDAQ_CENTER) + NIDAQ_DEN,
                                  2 * NIDAQ_DEN);
        default:    e = floor_div(2 * (longint'(win_sum) - DEF_CENTER) + DEF_DEN,
                                  2 * DEF_DEN);
      endcase
      if (e < longint'(EPOCH_MIN)) e = longint'(EPOCH_MIN);
      if (e > longint'(EPOCH_MAX)) e = longint'(EPOCH_MAX);
      epoch_q.push_back(TDATA_OUT_W'(e[EPOCH_W-1:0]));
      restart_frame();
    endfunction

    function void check_epoch(logic [TDATA_OUT_W-1:0] act_v);
      logic [TDATA_OUT_W-1:0] exp_v;
      if (epoch_q.size() == 0) begin
        log_mismatch("epoch beat with no frame outstanding", 'x, act_v);
        return;
      end
      exp_v = epoch_q.pop_front();
      if (act_v !== exp_v) log_mismatch("epoch", exp_v, act_v);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  mode_t                  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;   // [15:0] sample
  logic                   s_axis_tlast;   // last_in_frame
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;   // [11:0] epoch, [15:12] 0

  bit calm     = 1'b0;  // no idling on either side
  bit quiet    = 1'b0;  // no idling for the current phase
  bit hold_req = 1'b0;
  int cycle_count;

  epoch_scoreboard sb = new();

  always #5 clk = ~clk;

  analog_epoch_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata, s_axis_tlast);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_epoch(m_axis_tdata);
  end

  // result side: random stalls plus one long hold on request
  initial begin
    int n;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
      end else begin
        n = 0;
      end
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] make_sample(frame_style_t sty, int p,
                                                       logic [SAMPLE_W-1:0] lvl);
    int v;
    case (sty)
      STY_CONST: return lvl;
      STY_LEVEL: begin
        v = int'(lvl) + int'($urandom_range(0, 64)) - 32;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[SAMPLE_W-1:0];
      end
      STY_PULSE: begin
        if (p >= PULSE_FIRST && p <= PULSE_LAST) begin
          v = $urandom_range(0, 7);
          if (v <= 3) return HOLD_RESET;
          if (v <= 5) return SAMPLE_W'($urandom_range(0, 4079));
          if (v == 6) return SAMPLE_W'($urandom_range(4080, 65535));
          return EDGE_VALUES[4'($urandom_range(0, 8))];
        end
        return ($urandom_range(0, 15) == 0) ? EDGE_VALUES[4'($urandom_range(0, 8))] :
                                              HOLD_RESET;
      end
      default: begin
        if ($urandom_range(0, 3) == 0) return EDGE_VALUES[4'($urandom_range(0, 8))];
        return SAMPLE_W'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // positions first..stop-1 of a frame; close marks the final beat as last
  task automatic send_frame(input int first, input int stop, input frame_style_t sty,
                            input logic [SAMPLE_W-1:0] lvl, input logic close);
    for (int p = first; p < stop; p++)
      push_sample(make_sample(sty, p, lvl), close && (p == stop - 1));
  endtask

  // baseline frame with three chosen samples at positions 30 to 32 of the pulse region
  task automatic pulse_frame(input int len, input logic [SAMPLE_W-1:0] a,
                             input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] s;
    for (int p = 0; p < len; p++) begin
      s = (p == 30) ? a : (p == 31) ? b : (p == 32) ? c : HOLD_RESET;
      push_sample(s, p == len - 1);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    sb.set_mode(m);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d epochs outstanding", cycle_count, sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int           sent;
    int           frames;
    int           phase_left;
    int           flen;
    int           cut;
    int           r;
    frame_style_t sty;
    logic [SAMPLE_W-1:0] lvl;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= MODE_DEFAULT;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default averaging out of reset: empty window, full scale, exact half
    send_frame(0, 1, STY_CONST, 16'd0, 1'b1);
    send_frame(0, 44, STY_CONST, 16'hFFFF, 1'b1);
    for (int p = 0; p < 44; p++) push_sample((p == 43) ? 16'd2045 : HOLD_RESET, p == 43);

    write_mode(MODE_NIDAQ);
    send_frame(0, 35, STY_CONST, 16'd0, 1'b1);
    send_frame(0, 35, STY_CONST, 16'hFFFF, 1'b1);
    send_frame(0, 35, STY_CONST, 16'd33008, 1'b1);

    // pulse pick: no pulse, normal pulse, unqualified third sample, lowest epoch,
    // threshold values, small negative offset that truncates to zero
    write_mode(MODE_CMOS);
    send_frame(0, 48, STY_CONST, HOLD_RESET, 1'b1);
    pulse_frame(48, 16'd1000, 16'd3000, 16'd500);
    pulse_frame(33, 16'd1000, 16'd1000, 16'hFFFF);
    pulse_frame(33, 16'd1000, 16'd0, 16'd1);
    pulse_frame(33, 16'd4079, 16'd2049, 16'd4080);
    pulse_frame(33, 16'd2048, 16'd2047, 16'd4079);
    pulse_frame(48, 16'd100, 16'd2045, 16'd100);

    // unused mode code, and a frame long enough to pin the index
    write_mode(MODE_UNUSED);
    send_frame(0, 44, STY_NOISE, 16'd0, 1'b1);
    send_frame(0, 80, STY_NOISE, 16'd0, 1'b1);

    // mode switch inside a frame; both windows fill and the sum wraps
    write_mode(MODE_NIDAQ);
    send_frame(0, 36, STY_CONST, 16'hFFFF, 1'b0);
    write_mode(MODE_DEFAULT);
    send_frame(36, 46, STY_CONST, 16'hFFFF, 1'b1);

    sent       = 0;
    frames     = 0;
    phase_left = 0;
    while (sent < RAND_ITEMS || frames < RAND_FRAMES) begin
      if (sent >= CALM_AFTER) calm = 1'b1;
      if (phase_left == 0) begin
        write_mode(mode_t'($urandom_range(0, 3)));
        quiet      = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(3, 8);
      end

      if (frames == HOLD_AT_FRAME) begin
        // results back up behind a long hold while single-beat frames keep coming
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) push_sample(SAMPLE_W'($urandom_range(0, 65535)), 1'b1);
        sent   += 40;
        frames += 40;
        wait_idle();
      end

      r    = $urandom_range(0, 19);
      flen = (r < 7) ? $urandom_range(1, 26) :
             (r < 17) ? $urandom_range(44, 63) : $urandom_range(64, 90);
      r    = $urandom_range(0, 9);
      sty  = (r <= 1) ? STY_NOISE : (r <= 5) ? STY_PULSE : STY_LEVEL;
      lvl  = SAMPLE_W'($urandom_range(0, 65535));

      if (flen > 1 && $urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, flen - 1);
        send_frame(0, cut, sty, lvl, 1'b0);
        write_mode(mode_t'($urandom_range(0, 3)));
        send_frame(cut, flen, sty, lvl, 1'b1);
      end else begin
        send_frame(0, flen, sty, lvl, 1'b1);
      end
      sent += flen;
      frames++;
      phase_left--;
    end

    calm = 1'b1;
    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
